@@ design/html_to_text_filter_core_assert.svh @@
// Assertion macros for the HTML-to-text filter core.
`ifndef HTML_TO_TEXT_FILTER_CORE_ASSERT_SVH
`define HTML_TO_TEXT_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define HTF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising edge, during reset as well.
`define HTF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HTF_ASSERT(label, prop, msg)
`define HTF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ design/htf_pkg.sv @@
// Constants, types and name-matching functions for the HTML-to-text filter.
package htf_pkg;

    // Longest tag or entity name that is held.
    localparam int NAME_CHARS = 7;
    localparam int LEN_W      = $clog2(NAME_CHARS + 1);
    localparam int IDX_W      = $clog2(NAME_CHARS);

    // Result queue.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Byte codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    // Held name and a zero-padded literal one byte longer.
    typedef logic [NAME_CHARS-1:0][7:0] t_name;
    typedef logic [NAME_CHARS:0][7:0]   t_lit;

    // One result item in the output queue.
    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
    } t_result;

    // Turns a right-aligned string of n characters into a literal, first
    // character at index 0.
    function automatic t_lit make_lit(input logic [63:0] s, input int n);
        t_lit lit;
        lit = '0;
        for (int i = 0; i <= NAME_CHARS; i++) begin
            if (i < n) begin
                lit[i] = s[8*(n-1-i) +: 8];
            end
        end
        return lit;
    endfunction

    localparam t_lit LIT_P_END      = make_lit("/p", 2);
    localparam t_lit LIT_BR         = make_lit("br", 2);
    localparam t_lit LIT_TR_END     = make_lit("/tr", 3);
    localparam t_lit LIT_TITLE_END  = make_lit("/title", 6);
    localparam t_lit LIT_SCRIPT     = make_lit("script", 6);
    localparam t_lit LIT_SCRIPT_END = make_lit("/script", 7);
    localparam t_lit LIT_NBSP       = make_lit("nbsp", 4);

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Case-blind compare of a held name, ended by a zero byte or by its
    // length, with a lowercase literal. Only entries below len are looked at.
    function automatic logic name_is(input t_name buf_in, input logic [LEN_W-1:0] len,
                                     input t_lit lit);
        logic done;
        logic res;
        done = 1'b0;
        res  = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (!done && i < int'(len)) begin
                if (buf_in[i] == CH_NUL) begin
                    done = 1'b1;
                    res  = (lit[i] == CH_NUL);
                end else if (lit[i] == CH_NUL || to_lower(buf_in[i]) != lit[i]) begin
                    done = 1'b1;
                    res  = 1'b0;
                end
            end
        end
        if (!done) begin
            res = (lit[len] == CH_NUL);
        end
        return res;
    endfunction

endpackage

@@ design/html_to_text_filter_core.sv @@
// HTML-to-text filter: input register, single-pass byte decoder and result queue.
// A byte is held in the input register, then its results in the result queue, before they go out.
// Throughput: one input byte per cycle while the queue has room; the master side moves one result
// per cycle, so a byte that yields a text byte and the terminator puts two results in the queue.
// The four-entry result queue sets how far the output may stall before input is held off.
// Reset (synchronous, active low) clears all control state; held name bytes are not cleared.
`include "html_to_text_filter_core_assert.svh"

module html_to_text_filter_core
    import htf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // end_of_text
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state.
    logic             r_prev_space, n_prev_space;
    logic             r_tag_active, n_tag_active;
    logic [LEN_W-1:0] r_tag_len,    n_tag_len;
    t_name            r_tag_chars,  n_tag_chars;
    logic             r_script,     n_script;
    logic             r_ent_active, n_ent_active;
    logic [LEN_W-1:0] r_ent_len,    n_ent_len;
    t_name            r_ent_chars,  n_ent_chars;

    // Result queue.
    t_result [QDEPTH-1:0] r_queue;
    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;

    logic       s_fire;
    logic       proc_fire;
    logic       m_fire;
    logic       emit;
    logic [7:0] emit_ch;
    logic       as_text;
    logic       is_blank;
    t_result    res0;
    t_result    res1;
    logic [1:0] res_cnt;

    assign proc_fire     = r_in_valid && (r_count <= QCNT_W'(QDEPTH - 2));
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_queue[r_rd_ptr].ch;
    assign m_axis_tlast  = r_queue[r_rd_ptr].eot;

    // Input register: loads whenever the held byte moves on or none is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_fire) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    assign is_blank = (r_in_byte == CH_TAB) || (r_in_byte == CH_LF) ||
                      (r_in_byte == CH_CR)  || (r_in_byte == CH_SPACE);

    // Byte decoder: next state and the text byte, if any, for the held byte.
    always_comb begin
        n_prev_space = r_prev_space;
        n_tag_active = r_tag_active;
        n_tag_len    = r_tag_len;
        n_tag_chars  = r_tag_chars;
        n_script     = r_script;
        n_ent_active = r_ent_active;
        n_ent_len    = r_ent_len;
        n_ent_chars  = r_ent_chars;
        emit         = 1'b0;
        emit_ch      = CH_NUL;
        as_text      = 1'b0;

        if (r_script && !r_tag_active && r_in_byte != CH_LT) begin
            // Script body outside tags is dropped.
        end else if (is_blank) begin
            if (r_tag_active) begin
                if (r_tag_len < LEN_W'(NAME_CHARS)) begin
                    n_tag_chars[r_tag_len[IDX_W-1:0]] = CH_NUL;
                    n_tag_len = r_tag_len + 1'b1;
                end
            end else if (!r_prev_space) begin
                n_prev_space = 1'b1;
                emit         = 1'b1;
                emit_ch      = CH_SPACE;
            end
        end else begin
            n_prev_space = 1'b0;
            if (r_in_byte == CH_LT) begin
                n_tag_active = 1'b1;
                n_tag_len    = '0;
            end else if (r_in_byte == CH_GT) begin
                if (r_tag_active) begin
                    n_tag_active = 1'b0;
                    if (name_is(r_tag_chars, r_tag_len, LIT_P_END) ||
                        name_is(r_tag_chars, r_tag_len, LIT_BR) ||
                        name_is(r_tag_chars, r_tag_len, LIT_TR_END) ||
                        name_is(r_tag_chars, r_tag_len, LIT_TITLE_END)) begin
                        emit    = 1'b1;
                        emit_ch = CH_LF;
                    end else if (name_is(r_tag_chars, r_tag_len, LIT_SCRIPT)) begin
                        n_script = 1'b1;
                    end else if (name_is(r_tag_chars, r_tag_len, LIT_SCRIPT_END)) begin
                        n_script = 1'b0;
                    end
                end
            end else if (r_tag_active) begin
                if (r_tag_len < LEN_W'(NAME_CHARS)) begin
                    n_tag_chars[r_tag_len[IDX_W-1:0]] = r_in_byte;
                    n_tag_len = r_tag_len + 1'b1;
                end
            end else if (!r_ent_active && r_in_byte == CH_AMP) begin
                n_ent_active = 1'b1;
                n_ent_len    = '0;
            end else begin
                as_text = 1'b1;
                if (r_ent_active) begin
                    if (r_ent_len < LEN_W'(NAME_CHARS)) begin
                        as_text = 1'b0;
                        if (r_in_byte != CH_SEMI) begin
                            n_ent_chars[r_ent_len[IDX_W-1:0]] = r_in_byte;
                            n_ent_len = r_ent_len + 1'b1;
                        end else begin
                            n_ent_active = 1'b0;
                            emit         = 1'b1;
                            emit_ch      = name_is(r_ent_chars, r_ent_len, LIT_NBSP) ?
                                           CH_SPACE : CH_UNDER;
                        end
                    end else begin
                        // Entity too long: abandoned, the byte counts as text.
                        n_ent_active = 1'b0;
                    end
                end
                if (as_text && r_in_byte >= CH_SPACE) begin
                    emit    = 1'b1;
                    emit_ch = r_in_byte;
                end
            end
        end

        // The final byte of a document returns the decoder to its reset state.
        if (r_in_last) begin
            n_prev_space = 1'b0;
            n_tag_active = 1'b0;
            n_tag_len    = '0;
            n_script     = 1'b0;
            n_ent_active = 1'b0;
            n_ent_len    = '0;
        end
    end

    // Result items for the queue: the text byte first, then the terminator.
    always_comb begin
        res0.eot = 1'b1;
        res0.ch  = CH_NUL;
        res1.eot = 1'b1;
        res1.ch  = CH_NUL;
        if (emit) begin
            res0.eot = 1'b0;
            res0.ch  = emit_ch;
        end
        res_cnt = {1'b0, emit} + {1'b0, r_in_last};
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_space <= 1'b0;
            r_tag_active <= 1'b0;
            r_tag_len    <= '0;
            r_script     <= 1'b0;
            r_ent_active <= 1'b0;
            r_ent_len    <= '0;
        end else if (proc_fire) begin
            r_prev_space <= n_prev_space;
            r_tag_active <= n_tag_active;
            r_tag_len    <= n_tag_len;
            r_script     <= n_script;
            r_ent_active <= n_ent_active;
            r_ent_len    <= n_ent_len;
        end
        if (proc_fire) begin
            r_tag_chars <= n_tag_chars;
            r_ent_chars <= n_ent_chars;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (proc_fire) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(res_cnt);
            end
            if (m_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (proc_fire ? QCNT_W'(res_cnt) : '0)
                               - QCNT_W'(m_fire);
        end
        if (proc_fire && res_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
            if (res_cnt == 2'd2) begin
                r_queue[r_wr_ptr + 1'b1] <= res1;
            end
        end
    end

    // Checks.
    `HTF_ASSERT(a_queue_bound, r_count <= QCNT_W'(QDEPTH), "result queue overflow")
    `HTF_ASSERT(a_room_on_step,
        proc_fire |-> (r_count <= QCNT_W'(QDEPTH - 2)),
        "step without queue room")
    `HTF_ASSERT(a_last_clears,
        (proc_fire && r_in_last) |=>
            (!r_tag_active && !r_ent_active && !r_script && !r_prev_space),
        "state not cleared after final byte")
    `HTF_ASSERT(a_term_zero,
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CH_NUL),
        "terminator carries data")
    `HTF_ASSERT_ALWAYS(a_reset_empty,
        !i_rst_n |=> (r_count == '0 && !r_in_valid),
        "reset left items pending")

endmodule
